/* rtl/stcd_pkg.sv */
// shared constants, tables and pipeline types for the seconds to calendar converter
package stcd_pkg;

    // number of register stages from input to output register
    localparam int NUM_STAGES = 10;

    // field widths of the transactions
    localparam int SECONDS_W = 32;
    localparam int TDATA_OUT_W = 40;

    // reciprocal constants: floor(x * RECIP >> SHIFT) is exact over the used input range
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam int SHIFT_60 = 37;
    localparam logic [19:0] RECIP_3 = 20'hA_AAAB;
    localparam int SHIFT_3 = 21;
    localparam logic [15:0] RECIP_1461 = 16'd45934;
    localparam int SHIFT_1461 = 26;
    localparam logic [16:0] RECIP_7 = 17'd74899;
    localparam int SHIFT_7 = 19;

    // calendar constants
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
    localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
    localparam logic [10:0] DAYS_TWO_YEARS = 11'd731;
    localparam logic [10:0] DAYS_THREE_YEARS = 11'd1096;
    localparam logic [15:0] MARCH25_DOY = 16'd83;
    localparam logic [4:0] DST_HOUR = 5'd3;

    // month codes used by the summer time window
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_MAY = 4'd5;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_JUL = 4'd7;
    localparam logic [3:0] MONTH_AUG = 4'd8;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;

    // first day of year of each month, last entry is the year length
    localparam logic [8:0] COMMON_START [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] LEAP_START [0:12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    // month start lookup for common or leap year
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] val;
        val = 9'd0;
        if (idx <= 4'd12) begin
            val = leap ? LEAP_START[idx] : COMMON_START[idx];
        end
        return val;
    endfunction

    // everything one item carries down the pipeline
    typedef struct packed {
        logic [31:0] secs;
        logic [26:0] q60;
        logic [20:0] q3600;
        logic [15:0] days;
        logic [5:0]  quads;
        logic [12:0] wq;
        logic [10:0] in_quad;
        logic [1:0]  yq;
        logic [8:0]  doy;
        logic        leap;
        logic [7:0]  year;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [2:0]  wday;
        logic [15:0] d25;
        logic [12:0] wq25;
        logic [4:0]  mar;
        logic [4:0]  oct;
        logic        dst;
    } item_t;

endpackage

/* rtl/seconds_to_calendar_dst.sv */
// seconds count to calendar date and time converter with summer time shift
//
//  channel   | ports                                  | content
//  ----------+----------------------------------------+--------------------------------
//  input     | s_tvalid s_tready s_tdata[31:0]         | seconds since 2000-01-01
//  result    | m_tvalid m_tready m_tdata[39:0] m_tuser | calendar fields, summer time flag
//  config    | cfg_we cfg_wdata                        | dst_enable register
//
// ten register stages, input to output register; one transaction per cycle while not stalled
// the reciprocal multipliers and the month table search set the depth
// each stage has its own valid bit and ready, so bubbles close up while the output stalls
// aresetn clears the valid bits and dst_enable; the payload registers keep no reset
module seconds_to_calendar_dst
    import stcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input transaction
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SECONDS_W-1:0]   s_tdata,    // seconds_count[31:0]
    // result transaction
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // second[5:0] minute[11:6] hour[16:12]
                                               // day_of_month[21:17] month[25:22]
                                               // year_offset[33:26] weekday[36:34] zero[39:37]
    output logic [0:0]             m_tuser,    // dst_active[0]
    // configuration
    input  logic                   cfg_we,
    input  logic                   cfg_wdata
);

    item_t      stage_reg   [NUM_STAGES];
    item_t      stage_next  [NUM_STAGES];
    logic       valid_reg   [NUM_STAGES];
    logic       valid_next  [NUM_STAGES];
    logic       stage_ready [NUM_STAGES];
    logic       dst_enable_reg;
    logic       dst_enable_next;

    // configuration register
    always_comb begin
        dst_enable_next = cfg_we ? cfg_wdata : dst_enable_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_enable_reg <= 1'b0;
        end else begin
            dst_enable_reg <= dst_enable_next;
        end
    end

    // per-stage ready: a stage may load when empty or when the next one moves
    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign s_tready = stage_ready[0];

    // valid bits follow the data
    always_comb begin
        valid_next[0] = stage_ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_ready[i]) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // stage 0: minutes count by reciprocal of 60
    always_comb begin : s0_comb
        logic [63:0] prod;
        prod = 64'(s_tdata) * 64'(RECIP_60);
        stage_next[0] = '0;
        stage_next[0].secs = s_tdata;
        stage_next[0].q60 = prod[63:SHIFT_60];
    end

    // stage 1: second of minute, hours count
    always_comb begin : s1_comb
        logic [63:0] prod;
        logic [31:0] back;
        prod = 64'(stage_reg[0].q60) * 64'(RECIP_60);
        back = 32'(stage_reg[0].q60) * 32'd60;
        stage_next[1] = stage_reg[0];
        stage_next[1].sec = 6'(stage_reg[0].secs - back);
        stage_next[1].q3600 = 21'(prod[63:SHIFT_60]);
    end

    // stage 2: minute of hour, day count as hours / 24
    always_comb begin : s2_comb
        logic [37:0] prod;
        logic [26:0] back;
        prod = 38'(stage_reg[1].q3600[20:3]) * 38'(RECIP_3);
        back = 27'(stage_reg[1].q3600) * 27'd60;
        stage_next[2] = stage_reg[1];
        stage_next[2].min = 6'(stage_reg[1].q60 - back);
        stage_next[2].days = 16'(prod[37:SHIFT_3]);
    end

    // stage 3: hour of day, four-year blocks, weekday quotient
    always_comb begin : s3_comb
        logic [31:0] prod_q;
        logic [33:0] prod_w;
        logic [20:0] back;
        prod_q = 32'(stage_reg[2].days) * 32'(RECIP_1461);
        prod_w = (34'(stage_reg[2].days) + 34'd6) * 34'(RECIP_7);
        back = 21'(stage_reg[2].days) * 21'd24;
        stage_next[3] = stage_reg[2];
        stage_next[3].hour = 5'(stage_reg[2].q3600 - back);
        stage_next[3].quads = prod_q[31:SHIFT_1461];
        stage_next[3].wq = prod_w[31:SHIFT_7];
    end

    // stage 4: day within the four-year block, weekday
    always_comb begin : s4_comb
        logic [15:0] back_q;
        logic [16:0] back_w;
        back_q = 16'(stage_reg[3].quads) * 16'(DAYS_PER_QUAD);
        back_w = 17'(stage_reg[3].wq) * 17'd7;
        stage_next[4] = stage_reg[3];
        stage_next[4].in_quad = 11'(stage_reg[3].days - back_q);
        stage_next[4].wday = 3'((17'(stage_reg[3].days) + 17'd6) - back_w);
    end

    // stage 5: year within the block, day of year
    always_comb begin : s5_comb
        logic [10:0] base;
        stage_next[5] = stage_reg[4];
        if (stage_reg[4].in_quad >= DAYS_THREE_YEARS) begin
            stage_next[5].yq = 2'd3;
            base = DAYS_THREE_YEARS;
        end else if (stage_reg[4].in_quad >= DAYS_TWO_YEARS) begin
            stage_next[5].yq = 2'd2;
            base = DAYS_TWO_YEARS;
        end else if (stage_reg[4].in_quad >= DAYS_LEAP_YEAR) begin
            stage_next[5].yq = 2'd1;
            base = DAYS_LEAP_YEAR;
        end else begin
            stage_next[5].yq = 2'd0;
            base = 11'd0;
        end
        stage_next[5].doy = 9'(stage_reg[4].in_quad - base);
        stage_next[5].leap = (stage_next[5].yq == 2'd0);
        stage_next[5].year = {stage_reg[4].quads, stage_next[5].yq};
    end

    // stage 6: month search, day of month, day number of 25 march
    always_comb begin : s6_comb
        logic [3:0]  mon;
        logic [8:0]  first;
        logic [15:0] leaps;
        mon = 4'd1;
        for (int i = 12; i >= 1; i--) begin
            if (stage_reg[5].doy < month_start(stage_reg[5].leap, 4'(i))) begin
                mon = 4'(i);
            end
        end
        first = month_start(stage_reg[5].leap, mon - 4'd1);
        leaps = (stage_reg[5].year != 8'd0)
              ? 16'(((stage_reg[5].year - 8'd1) >> 2) + 8'd1) : 16'd0;
        stage_next[6] = stage_reg[5];
        stage_next[6].month = mon;
        stage_next[6].mday = 5'(stage_reg[5].doy - first + 9'd1);
        stage_next[6].d25 = 16'(stage_reg[5].year) * 16'd365 + leaps + MARCH25_DOY
                          + 16'(stage_reg[5].leap);
    end

    // stage 7: weekday quotient of 25 march
    always_comb begin : s7_comb
        logic [33:0] prod;
        prod = (34'(stage_reg[6].d25) + 34'd6) * 34'(RECIP_7);
        stage_next[7] = stage_reg[6];
        stage_next[7].wq25 = prod[31:SHIFT_7];
    end

    // stage 8: last sundays of march and october
    always_comb begin : s8_comb
        logic [16:0] back;
        logic [2:0]  w25;
        logic [4:0]  oct_raw;
        back = 17'(stage_reg[7].wq25) * 17'd7;
        w25 = 3'((17'(stage_reg[7].d25) + 17'd6) - back);
        stage_next[8] = stage_reg[7];
        stage_next[8].mar = (w25 == 3'd0) ? 5'd25 : 5'd25 + (5'd7 - 5'(w25));
        oct_raw = stage_next[8].mar + 5'd3;
        stage_next[8].oct = (stage_next[8].mar > 5'd28) ? stage_next[8].mar - 5'd4 : oct_raw;
    end

    // stage 9: summer time window and hour shift with day and month rollover
    always_comb begin : s9_comb
        logic       on;
        logic [5:0] mday_inc;
        logic       short_month;
        logic       long_month;
        item_t      cur;
        cur = stage_reg[8];
        on = dst_enable_reg
          && ((cur.month > MONTH_MAR && cur.month < MONTH_OCT)
           || (cur.month == MONTH_MAR
               && (cur.mday > cur.mar || (cur.mday == cur.mar && cur.hour >= DST_HOUR)))
           || (cur.month == MONTH_OCT
               && (cur.mday < cur.oct || (cur.mday == cur.oct && cur.hour < DST_HOUR))));
        mday_inc = 6'(cur.mday) + 6'd1;
        short_month = (cur.month == MONTH_APR) || (cur.month == MONTH_JUN)
                   || (cur.month == MONTH_SEP);
        long_month = (cur.month == MONTH_MAR) || (cur.month == MONTH_MAY)
                  || (cur.month == MONTH_JUL) || (cur.month == MONTH_AUG);
        stage_next[9] = cur;
        stage_next[9].dst = on;
        if (on) begin
            if (cur.hour == 5'd23) begin
                stage_next[9].hour = 5'd0;
                if ((mday_inc > 6'd30 && short_month) || (mday_inc > 6'd31 && long_month)) begin
                    stage_next[9].mday = 5'd1;
                    stage_next[9].month = cur.month + 4'd1;
                end else begin
                    stage_next[9].mday = 5'(mday_inc);
                end
            end else begin
                stage_next[9].hour = cur.hour + 5'd1;
            end
        end
    end

    // output register drives the result channel
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata = {3'b000,
                      stage_reg[NUM_STAGES-1].wday,
                      stage_reg[NUM_STAGES-1].year,
                      stage_reg[NUM_STAGES-1].month,
                      stage_reg[NUM_STAGES-1].mday,
                      stage_reg[NUM_STAGES-1].hour,
                      stage_reg[NUM_STAGES-1].min,
                      stage_reg[NUM_STAGES-1].sec};
    assign m_tuser = stage_reg[NUM_STAGES-1].dst;

endmodule

/* rtl/stcd_checker.sv */
// port-level checker for the seconds to calendar converter and its bind
module stcd_checker
    import stcd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transaction changed");

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // time of day and weekday fields in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:0] < 6'd60 && m_tdata[11:6] < 6'd60 && m_tdata[16:12] < 5'd24
                     && m_tdata[36:34] < 3'd7)
        else $error("time field out of range");

    // date fields in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[21:17] != 5'd0 && m_tdata[25:22] != 4'd0
                     && m_tdata[25:22] <= 4'd12 && m_tdata[33:26] <= 8'd136)
        else $error("date field out of range");

    // summer time only between march and october
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[25:22] >= MONTH_MAR && m_tdata[25:22] <= MONTH_OCT)
        else $error("summer time flag outside march to october");

endmodule

bind seconds_to_calendar_dst stcd_checker u_stcd_checker (.*);
